[sv/dccpwg_pkg.sv]
// shared types and constants for the dcc packet waveform generator
package dccpwg_pkg;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_IDLE  = 2'd1,
		ACT_SPEED = 2'd2,
		ACT_FUNC  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		REG_ONE_HALF  = 2'd0,
		REG_ZERO_HALF = 2'd1,
		REG_PREAMBLE  = 2'd2,
		REG_REPEAT    = 2'd3
	} reg_index_t;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] ONE_HALF_RESET  = 8'd58;
	localparam logic [7:0] ZERO_HALF_RESET = 8'd100;
	localparam logic [4:0] PREAMBLE_RESET  = 5'd14;
	localparam logic [3:0] REPEAT_RESET    = 4'd3;

	localparam logic [7:0] BYTE_ONES   = 8'hFF;
	localparam logic [7:0] BYTE_ZERO   = 8'h00;
	localparam logic [7:0] FUNC_GROUP  = 8'h80;
	localparam logic [7:0] SPEED_INSTR = 8'h3F;
	localparam logic [7:0] SPEED_MAX   = 8'd127;

	typedef struct packed {
		logic [7:0] one_half;
		logic [7:0] zero_half;
		logic [4:0] preamble;
		logic [3:0] repeats;
	} cfg_t;

	// classified request as it sits in the queue
	typedef struct packed {
		action_t     kind;
		logic [6:0]  address;
		logic [31:0] bytes;
		logic [4:0]  mask;
		logic        on;
	} item_t;

endpackage

[sv/dcc_packet_waveform_generator.sv]
// top level of the dcc packet waveform generator
//
//  channel  | handshake                        | payload
//  ---------+----------------------------------+------------------------------------------
//  in       | in_valid / in_stall              | action address forward speed
//           |                                  | function_mask switch_on
//  out      | out_valid / out_stall            | rail_a rail_b busy_res accepted
//  cfg      | cfg_we (cfg_index, cfg_data)     | one_half, zero_half, preamble, repeat
//
// one request per clock sustained while out_stall allows; each request passes the queue, then
// the result register (read straight from the queue); back end retires one per unstalled cycle
// in_stall rises only when the QUEUE_DEPTH-entry queue is full
// out_stall holds the result register; the queue keeps absorbing requests meanwhile
// arst_n clears all packet state and loads the register defaults at once
module dcc_packet_waveform_generator #(
	parameter int QUEUE_DEPTH = dccpwg_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] action,
	input  logic [6:0] address,
	input  logic       forward,
	input  logic [7:0] speed,
	input  logic [4:0] function_mask,
	input  logic       switch_on,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       rail_a,
	output logic       rail_b,
	output logic       busy_res,
	output logic       accepted,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	dccpwg_pkg::cfg_t  cfg_q;
	dccpwg_pkg::item_t front_item;
	dccpwg_pkg::item_t q_item;
	logic              push;
	logic              pop;
	logic              q_valid;
	logic              q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.one_half  <= dccpwg_pkg::ONE_HALF_RESET;
			cfg_q.zero_half <= dccpwg_pkg::ZERO_HALF_RESET;
			cfg_q.preamble  <= dccpwg_pkg::PREAMBLE_RESET;
			cfg_q.repeats   <= dccpwg_pkg::REPEAT_RESET;
		end else if (cfg_we) begin
			case (dccpwg_pkg::reg_index_t'(cfg_index))
				dccpwg_pkg::REG_ONE_HALF:  cfg_q.one_half  <= cfg_data;
				dccpwg_pkg::REG_ZERO_HALF: cfg_q.zero_half <= cfg_data;
				dccpwg_pkg::REG_PREAMBLE:  cfg_q.preamble  <= cfg_data[4:0];
				dccpwg_pkg::REG_REPEAT:    cfg_q.repeats   <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	dccpwg_front u_front (
		.action        (in_valid),
		.action_code   (action),
		.address       (address),
		.forward       (forward),
		.speed         (speed),
		.function_mask (function_mask),
		.switch_on     (switch_on),
		.queue_full    (q_full),
		.push          (push),
		.in_stall      (in_stall),
		.item          (front_item)
	);

	dccpwg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_item   (front_item),
		.pop       (pop),
		.rd_item   (q_item),
		.not_empty (q_valid),
		.full      (q_full)
	);

	dccpwg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.rail_a    (rail_a),
		.rail_b    (rail_b),
		.busy_res  (busy_res),
		.accepted  (accepted)
	);

endmodule

[sv/dccpwg_front.sv]
// front end: takes requests and classifies them, building idle and speed packets
module dccpwg_front (
	input  logic                action,
	input  logic [1:0]          action_code,
	input  logic [6:0]          address,
	input  logic                forward,
	input  logic [7:0]          speed,
	input  logic [4:0]          function_mask,
	input  logic                switch_on,
	input  logic                queue_full,
	output logic                push,
	output logic                in_stall,
	output dccpwg_pkg::item_t   item
);
	logic [7:0] sat;
	logic [7:0] speed_byte;
	logic [7:0] addr_byte;

	assign in_stall   = queue_full;
	assign push       = action & ~queue_full;
	assign sat        = (speed > dccpwg_pkg::SPEED_MAX) ? dccpwg_pkg::SPEED_MAX : speed;
	assign speed_byte = {forward, sat[6:0]};
	assign addr_byte  = {1'b0, address};

	always_comb begin
		item.kind    = dccpwg_pkg::action_t'(action_code);
		item.address = address;
		item.mask    = function_mask;
		item.on      = switch_on;
		case (dccpwg_pkg::action_t'(action_code))
			dccpwg_pkg::ACT_IDLE: begin
				item.bytes = {dccpwg_pkg::BYTE_ONES, dccpwg_pkg::BYTE_ZERO,
					dccpwg_pkg::BYTE_ONES, dccpwg_pkg::BYTE_ZERO};
			end
			dccpwg_pkg::ACT_SPEED: begin
				item.bytes = {addr_byte, dccpwg_pkg::SPEED_INSTR, speed_byte,
					addr_byte ^ dccpwg_pkg::SPEED_INSTR ^ speed_byte};
			end
			default: begin
				// function packets need the kept state, built at the back end
				item.bytes = '0;
			end
		endcase
	end

endmodule

[sv/dccpwg_queue.sv]
// short fifo between front and back ends
module dccpwg_queue #(
	parameter int DEPTH = dccpwg_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dccpwg_pkg::item_t wr_item,
	input  logic              pop,
	output dccpwg_pkg::item_t rd_item,
	output logic              not_empty,
	output logic              full
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	dccpwg_pkg::item_t entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == FULL_COUNT);
	assign not_empty = (count_q != '0);
	assign rd_item   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

[sv/dccpwg_back.sv]
// back end: packet state, bit sequencer, half-bit timer and result register
module dccpwg_back (
	input  logic              clk,
	input  logic              arst_n,
	input  dccpwg_pkg::cfg_t  cfg,
	input  logic              q_valid,
	input  dccpwg_pkg::item_t q_item,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              rail_a,
	output logic              rail_b,
	output logic              busy_res,
	output logic              accepted
);
	logic [4:0]  func_q;
	logic [31:0] bytes_q;
	logic [2:0]  count_q;
	logic [5:0]  pos_q;
	logic        cur_q;
	logic        phase_q;
	logic [7:0]  timer_q;
	logic [3:0]  reps_q;
	logic        sending_q;
	logic        sent_once_q;
	logic        out_valid_q;

	logic [4:0]  n_func;
	logic [31:0] n_bytes;
	logic [2:0]  n_count;
	logic [5:0]  n_pos;
	logic        n_cur;
	logic        n_phase;
	logic [7:0]  n_timer;
	logic [3:0]  n_reps;
	logic        n_sending;
	logic        n_sent_once;

	logic        ra;
	logic        rb;
	logic        acc;
	logic        start;
	logic        load;
	logic        bit_v;
	logic [5:0]  np;
	logic [5:0]  nine_n;
	logic [3:0]  reps_cfg;
	logic [7:0]  b0;
	logic [7:0]  b1;
	logic [4:0]  fs_new;

	function automatic logic [7:0] half_len(input logic v, input dccpwg_pkg::cfg_t c);
		logic [7:0] t;
		t = v ? c.one_half : c.zero_half;
		return (t == 8'd0) ? 8'd1 : t;
	endfunction

	// position splits into byte k and slot j (slot 0 is the start bit), k = pos*57 >> 9
	function automatic logic bit_at(input logic so, input logic [5:0] pos,
			input logic [31:0] b, input logic [2:0] n);
		logic [11:0] prod;
		logic [2:0]  k;
		logic [5:0]  j;
		logic [5:0]  lim;
		logic [5:0]  idx;
		prod = {6'd0, pos} * 12'd57;
		k    = prod[11:9];
		j    = pos - ({k, 3'b000} + {3'b000, k});
		lim  = {n, 3'b000} + {3'b000, n};
		idx  = 6'd32 - {1'b0, k[1:0], 3'b000} - j;
		if (!so || pos >= lim) begin
			return 1'b1;
		end else if (j == 6'd0 || k > 3'd3) begin
			return 1'b0;
		end else begin
			return b[idx[4:0]];
		end
	endfunction

	assign pop       = q_valid & (~out_valid_q | ~out_stall);
	assign out_valid = out_valid_q;
	assign nine_n    = {count_q, 3'b000} + {3'b000, count_q};
	assign reps_cfg  = (cfg.repeats == 4'd0) ? 4'd1 : cfg.repeats;
	assign b0        = {1'b0, q_item.address};
	assign fs_new    = q_item.on ? (func_q | q_item.mask) : (func_q & ~q_item.mask);
	assign b1        = dccpwg_pkg::FUNC_GROUP | {3'b000, fs_new};

	always_comb begin
		n_func      = func_q;
		n_bytes     = bytes_q;
		n_count     = count_q;
		n_pos       = pos_q;
		n_cur       = cur_q;
		n_phase     = phase_q;
		n_timer     = timer_q;
		n_reps      = reps_q;
		n_sending   = sending_q;
		n_sent_once = sent_once_q;
		ra          = 1'b0;
		rb          = 1'b0;
		acc         = 1'b0;
		start       = 1'b0;
		load        = 1'b0;
		np          = pos_q + 6'd1;
		bit_v       = 1'b0;

		if (q_item.kind == dccpwg_pkg::ACT_TICK) begin
			if (sending_q) begin
				ra = ~phase_q;
				rb = phase_q;
				if (timer_q > 8'd1) begin
					n_timer = timer_q - 8'd1;
				end else if (!phase_q) begin
					n_phase = 1'b1;
					n_timer = half_len(cur_q, cfg);
				end else if (!sent_once_q) begin
					// preamble ends as soon as the count reaches the configured length
					if (np >= {1'b0, cfg.preamble}) begin
						n_sent_once = 1'b1;
						n_pos       = 6'd0;
					end else begin
						n_pos = np;
					end
					load = 1'b1;
				end else if (pos_q >= nine_n) begin
					if (reps_q > 4'd1) begin
						n_reps = reps_q - 4'd1;
						start  = 1'b1;
					end else begin
						n_reps    = 4'd0;
						n_sending = 1'b0;
						n_phase   = 1'b0;
						n_timer   = 8'd0;
					end
				end else begin
					n_pos = np;
					load  = 1'b1;
				end
			end
		end else if (!sending_q) begin
			acc       = 1'b1;
			n_sending = 1'b1;
			start     = 1'b1;
			case (q_item.kind)
				dccpwg_pkg::ACT_IDLE: begin
					n_bytes = q_item.bytes;
					n_count = 3'd3;
					n_reps  = 4'd1;
				end
				dccpwg_pkg::ACT_SPEED: begin
					n_bytes = q_item.bytes;
					n_count = 3'd4;
					n_reps  = reps_cfg;
				end
				default: begin
					n_func  = fs_new;
					n_bytes = {b0, b1, b0 ^ b1, dccpwg_pkg::BYTE_ZERO};
					n_count = 3'd3;
					n_reps  = reps_cfg;
				end
			endcase
		end

		if (start) begin
			n_pos       = 6'd0;
			n_sent_once = (cfg.preamble == 5'd0);
			load        = 1'b1;
		end
		if (load) begin
			bit_v   = bit_at(n_sent_once, n_pos, n_bytes, n_count);
			n_cur   = bit_v;
			n_phase = 1'b0;
			n_timer = half_len(bit_v, cfg);
		end
		if (q_item.kind != dccpwg_pkg::ACT_TICK && n_sending) begin
			ra = ~n_phase;
			rb = n_phase;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			func_q      <= '0;
			bytes_q     <= '0;
			count_q     <= '0;
			pos_q       <= '0;
			cur_q       <= 1'b0;
			phase_q     <= 1'b0;
			timer_q     <= '0;
			reps_q      <= '0;
			sending_q   <= 1'b0;
			sent_once_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				func_q      <= n_func;
				bytes_q     <= n_bytes;
				count_q     <= n_count;
				pos_q       <= n_pos;
				cur_q       <= n_cur;
				phase_q     <= n_phase;
				timer_q     <= n_timer;
				reps_q      <= n_reps;
				sending_q   <= n_sending;
				sent_once_q <= n_sent_once;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rail_a   <= ra;
			rail_b   <= rb;
			busy_res <= n_sending;
			accepted <= acc;
		end
	end

endmodule

[sv/dccpwg_checker.sv]
// port-level checks for the dcc packet waveform generator, bound to the top level
module dccpwg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       rail_a,
	input logic       rail_b,
	input logic       busy_res,
	input logic       accepted
);

	// a taken command always starts on the high half of its first bit
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> rail_a && !rail_b && busy_res)
		else $error("accepted command did not start a packet on the high half");

	// the rails are never driven high together
	a_rails_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(rail_a && rail_b))
		else $error("both rails high");

	// quiet rails only come from an idle generator
	a_quiet_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !rail_a && !rail_b |-> !busy_res && !accepted)
		else $error("rails low while a packet is in progress");

	// a stalled result is held
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(rail_a) && $stable(rail_b)
			&& $stable(busy_res) && $stable(accepted))
		else $error("stalled result changed");

endmodule

bind dcc_packet_waveform_generator dccpwg_checker u_dccpwg_checker (.*);
